// ===== hw/rtl/gbts_pkg.sv =====
package gbts_pkg;

   localparam int BUFFER_DEPTH = 4096;
   localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
   localparam int FIELD_W = 13;
   localparam int CMP_W = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
   localparam int DATA_W = 8;
   localparam int KIND_W = 3;
   localparam int STATUS_W = 2;

   localparam logic [KIND_W-1:0] K_INSERT = 3'd0;
   localparam logic [KIND_W-1:0] K_DEL_BEFORE = 3'd1;
   localparam logic [KIND_W-1:0] K_DEL_AFTER = 3'd2;
   localparam logic [KIND_W-1:0] K_MOVE = 3'd3;
   localparam logic [KIND_W-1:0] K_READ = 3'd4;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK = 2'd0,
      ST_FULL = 2'd1,
      ST_NODEL = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // one write and one read access to the text memory per cycle
   typedef struct packed {
      logic rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
   } mem_req_type;

endpackage

// ===== hw/rtl/gbts_store.sv =====
module gbts_store
   import gbts_pkg::*;
(
   input logic clock,
   input mem_req_type mem_req,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [BUFFER_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      // read data holds until the next read
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/gap_buffer_text_store.sv =====
// channel  direction  handshake            word
// req_     in         req_valid/req_ready  kind, position, data_in
// rsp_     out        rsp_valid/rsp_ready  data_out, length, cursor, status
//
// insert, delete, read and refused requests are accepted in the idle state, then answered from the result state
// a cursor move over n bytes copies one byte per cycle
// through the single read and single write port of the text memory
// reset is synchronous; cursor and length go to zero, gap end to the buffer depth,
// the memory is left as it is
// a result waiting on rsp_ready holds the block in its result state
module gap_buffer_text_store
   import gbts_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [KIND_W-1:0] req_kind,
   input logic [FIELD_W-1:0] req_position,
   input logic [DATA_W-1:0] req_data_in,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [DATA_W-1:0] rsp_data_out,
   output logic [FIELD_W-1:0] rsp_length,
   output logic [FIELD_W-1:0] rsp_cursor,
   output logic [STATUS_W-1:0] rsp_status
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MOVE,
      S_DONE
   } state_type;

   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUFFER_DEPTH);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] gf_ff, gf_in;
   logic [CNT_W-1:0] gl_ff, gl_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0] mv_src_ff, mv_src_in;
   logic [ADDR_W-1:0] mv_dst_ff, mv_dst_in;
   logic [CNT_W-1:0] mv_rem_ff, mv_rem_in;
   logic [CNT_W-1:0] mv_pos_ff, mv_pos_in;
   logic mv_left_ff, mv_left_in;
   logic mv_pend_ff, mv_pend_in;
   logic sel_rd_ff, sel_rd_in;
   status_type status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [FIELD_W-1:0] rsp_length_ff, rsp_length_in;
   logic [FIELD_W-1:0] rsp_cursor_ff, rsp_cursor_in;
   status_type rsp_status_ff, rsp_status_in;

   mem_req_type mem_req;
   logic [DATA_W-1:0] rd_data;

   logic [CNT_W-1:0] gsize;
   logic [CMP_W-1:0] pos_c;
   logic [CMP_W-1:0] cnt_c;
   logic [CNT_W-1:0] pos_n;
   logic [CNT_W-1:0] phys;

   gbts_store u_store (
      .clock(clock),
      .mem_req(mem_req),
      .rd_data(rd_data)
   );

   assign gsize = gl_ff - gf_ff;
   assign pos_c = CMP_W'(req_position);
   assign cnt_c = CMP_W'(cnt_ff);
   assign pos_n = CNT_W'(req_position);
   // logical to physical: skip the gap for positions at or after the cursor
   assign phys = (pos_n < gf_ff) ? pos_n : pos_n + gsize;

   always_comb begin
      state_in = state_ff;
      gf_in = gf_ff;
      gl_in = gl_ff;
      cnt_in = cnt_ff;
      mv_src_in = mv_src_ff;
      mv_dst_in = mv_dst_ff;
      mv_rem_in = mv_rem_ff;
      mv_pos_in = mv_pos_ff;
      mv_left_in = mv_left_ff;
      mv_pend_in = mv_pend_ff;
      sel_rd_in = sel_rd_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      rsp_length_in = rsp_length_ff;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_status_in = rsp_status_ff;
      mem_req = '0;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sel_rd_in = 1'b0;
               status_in = ST_OK;
               state_in = S_DONE;
               case (req_kind)
                  K_INSERT: begin
                     if (gf_ff < gl_ff) begin
                        mem_req.wr_en = 1'b1;
                        mem_req.wr_addr = ADDR_W'(gf_ff);
                        mem_req.wr_data = req_data_in;
                        gf_in = gf_ff + CNT_W'(1);
                        cnt_in = cnt_ff + CNT_W'(1);
                     end else begin
                        status_in = ST_FULL;
                     end
                  end
                  K_DEL_BEFORE: begin
                     if (gf_ff != '0) begin
                        mem_req.rd_en = 1'b1;
                        mem_req.rd_addr = ADDR_W'(gf_ff - CNT_W'(1));
                        sel_rd_in = 1'b1;
                        gf_in = gf_ff - CNT_W'(1);
                        cnt_in = cnt_ff - CNT_W'(1);
                     end else begin
                        status_in = ST_NODEL;
                     end
                  end
                  K_DEL_AFTER: begin
                     if (gl_ff < DEPTH_C) begin
                        mem_req.rd_en = 1'b1;
                        mem_req.rd_addr = ADDR_W'(gl_ff);
                        sel_rd_in = 1'b1;
                        gl_in = gl_ff + CNT_W'(1);
                        cnt_in = cnt_ff - CNT_W'(1);
                     end else begin
                        status_in = ST_NODEL;
                     end
                  end
                  K_MOVE: begin
                     if (pos_c > cnt_c) begin
                        status_in = ST_RANGE;
                     end else if (pos_n != gf_ff) begin
                        mv_pos_in = pos_n;
                        mv_pend_in = 1'b0;
                        state_in = S_MOVE;
                        if (pos_n < gf_ff) begin
                           // copy down from the byte before the cursor
                           mv_left_in = 1'b1;
                           mv_rem_in = gf_ff - pos_n;
                           mv_src_in = ADDR_W'(gf_ff - CNT_W'(1));
                        end else begin
                           mv_left_in = 1'b0;
                           mv_rem_in = pos_n - gf_ff;
                           mv_src_in = ADDR_W'(gl_ff);
                        end
                     end
                  end
                  K_READ: begin
                     if (pos_c >= cnt_c) begin
                        status_in = ST_RANGE;
                     end else begin
                        mem_req.rd_en = 1'b1;
                        mem_req.rd_addr = ADDR_W'(phys);
                        sel_rd_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_MOVE: begin
            // write back the byte read last cycle
            if (mv_pend_ff) begin
               mem_req.wr_en = 1'b1;
               mem_req.wr_addr = mv_dst_ff;
               mem_req.wr_data = rd_data;
            end
            if (mv_rem_ff != '0) begin
               mem_req.rd_en = 1'b1;
               mem_req.rd_addr = mv_src_ff;
               mv_pend_in = 1'b1;
               mv_rem_in = mv_rem_ff - CNT_W'(1);
               if (mv_left_ff) begin
                  mv_dst_in = mv_src_ff + ADDR_W'(gsize);
                  mv_src_in = mv_src_ff - ADDR_W'(1);
               end else begin
                  mv_dst_in = mv_src_ff - ADDR_W'(gsize);
                  mv_src_in = mv_src_ff + ADDR_W'(1);
               end
            end else begin
               mv_pend_in = 1'b0;
               gf_in = mv_pos_ff;
               gl_in = mv_pos_ff + gsize;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = sel_rd_ff ? rd_data : '0;
               rsp_length_in = FIELD_W'(cnt_ff);
               rsp_cursor_in = FIELD_W'(gf_ff);
               rsp_status_in = status_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mv_src_ff <= mv_src_in;
      mv_dst_ff <= mv_dst_in;
      mv_rem_ff <= mv_rem_in;
      mv_pos_ff <= mv_pos_in;
      mv_left_ff <= mv_left_in;
      sel_rd_ff <= sel_rd_in;
      status_ff <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_length_ff <= rsp_length_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff <= S_IDLE;
         gf_ff <= '0;
         gl_ff <= DEPTH_C;
         cnt_ff <= '0;
         mv_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         gf_ff <= gf_in;
         gl_ff <= gl_in;
         cnt_ff <= cnt_in;
         mv_pend_ff <= mv_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_length = rsp_length_ff;
   assign rsp_cursor = rsp_cursor_ff;
   assign rsp_status = rsp_status_ff;

   // text plus gap always fills the buffer
   a_size_sum: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff + gsize) == DEPTH_C)
      else $error("length and gap size do not add up to the buffer depth");

   a_gap_order: assert property (@(posedge clock) disable iff (reset)
      gf_ff <= gl_ff)
      else $error("gap start beyond gap end");

   a_move_wb: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE && mv_pend_ff) |-> $past(mem_req.rd_en))
      else $error("move write-back without a preceding read");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result word raised outside the result state");

   a_idle_no_move: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mv_pend_ff)
      else $error("pending move write left over in idle");

endmodule
